// ----- hdl/assert_macros.svh -----
// Assertion macros used by the deframer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check an implication on every clock edge outside reset
`define CHK_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("check failed");
// check an implication in the next cycle
`define CHK_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("check failed");
`endif

// ----- hdl/lrd_pkg.sv -----
// Package of types, constants and functions for the log record deframer
package lrd_pkg;
	localparam int LEN_WIDTH = 32;
	localparam int HEADER_BYTES = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam logic [31:0] CRC_POLY = 32'h82F63B78;

	typedef enum logic [2:0] {
		KIND_TYPE = 3'd0,
		KIND_KEY = 3'd1,
		KIND_VALUE = 3'd2,
		KIND_END = 3'd3,
		KIND_FINAL = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BAD_KLEN = 3'd1,
		ST_SHORT_KEY = 3'd2,
		ST_BAD_VLEN = 3'd3,
		ST_SHORT_VAL = 3'd4,
		ST_CRC_BAD = 3'd5
	} status_t;

	typedef struct packed {
		logic action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] result_kind;
		logic [7:0] out_byte;
		logic [7:0] record_kind;
		logic [2:0] status;
		logic last;
	} out_item_t;

	// front-to-back slot: up to two results of one input byte
	typedef struct packed {
		logic two;
		out_item_t r0;
		out_item_t r1;
	} slot_t;

	function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction
endpackage

// ----- hdl/lrd_front.sv -----
// Front part: parses the byte stream and produces result slots
module lrd_front import lrd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     strict,
	input  logic     in_valid,
	input  in_item_t in_item,
	output logic     slot_valid,
	output slot_t    slot
);
	typedef enum logic [2:0] {
		PH_CRC, PH_TYPE, PH_KLEN, PH_KEY, PH_VLEN, PH_VAL
	} phase_t;

	phase_t phase_q;
	logic [1:0] hdr_cnt_q;
	logic [31:0] stored_q, crc_q, acc_q;
	logic [2:0] vcnt_q;
	logic [LEN_WIDTH-1:0] rem_q;
	logic [7:0] type_q;
	logic halted_q;
	status_t perr_q;

	logic [7:0] b;
	logic [31:0] crc_n, acc_n, shifted;
	logic [2:0] vcnt_n;
	logic vdone, vbad, crc_ok;
	logic [LEN_WIDTH-1:0] rem_dec;

	assign b = in_item.data_byte;
	assign crc_n = crc_byte(crc_q, b);
	assign crc_ok = (~crc_n) == stored_q;
	assign rem_dec = rem_q - LEN_WIDTH'(1);

	always_comb begin
		shifted = 32'd0;
		case (vcnt_q)
			3'd0: shifted = {25'd0, b[6:0]};
			3'd1: shifted = {18'd0, b[6:0], 7'd0};
			3'd2: shifted = {11'd0, b[6:0], 14'd0};
			3'd3: shifted = {4'd0, b[6:0], 21'd0};
			3'd4: shifted = {b[3:0], 28'd0};
			default: shifted = 32'd0;
		endcase
		acc_n = acc_q | shifted;
		vcnt_n = vcnt_q + 3'd1;
		vdone = !b[7];
		vbad = b[7] ? (vcnt_n >= 3'd5) : ((acc_n >> (LEN_WIDTH - 1)) > 32'd1);
	end

	function automatic out_item_t mk(kind_t k, logic [7:0] ob, logic [7:0] rk,
		status_t s, logic l);
		out_item_t r;
		r.result_kind = k;
		r.out_byte = ob;
		r.record_kind = rk;
		r.status = s;
		r.last = l;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CRC;
			hdr_cnt_q <= '0;
			stored_q <= '0;
			crc_q <= '1;
			acc_q <= '0;
			vcnt_q <= '0;
			rem_q <= '0;
			type_q <= '0;
			halted_q <= 1'b0;
			perr_q <= ST_OK;
			slot_valid <= 1'b0;
			slot <= '0;
		end else begin
			slot_valid <= 1'b0;
			if (in_valid) begin
				if (in_item.action) begin
					status_t st;
					st = ST_OK;
					if (halted_q) st = perr_q;
					else if (phase_q == PH_KLEN) st = ST_BAD_KLEN;
					else if (phase_q == PH_KEY) st = ST_SHORT_KEY;
					else if (phase_q == PH_VLEN) st = ST_BAD_VLEN;
					else if (phase_q == PH_VAL) st = ST_SHORT_VAL;
					if (!strict) st = ST_OK;
					slot_valid <= 1'b1;
					slot.two <= 1'b0;
					slot.r0 <= mk(KIND_FINAL, 8'd0, type_q, st, 1'b1);
					phase_q <= PH_CRC;
					hdr_cnt_q <= '0;
					stored_q <= '0;
					crc_q <= '1;
					acc_q <= '0;
					vcnt_q <= '0;
					rem_q <= '0;
					type_q <= '0;
					halted_q <= 1'b0;
					perr_q <= ST_OK;
				end else if (!halted_q) begin
					if (phase_q == PH_CRC) begin
						stored_q[8*hdr_cnt_q +: 8] <= b;
						hdr_cnt_q <= hdr_cnt_q + 2'd1;
						if (hdr_cnt_q == 2'(HEADER_BYTES - 1)) begin
							phase_q <= PH_TYPE;
							crc_q <= '1;
						end
					end else begin
						crc_q <= crc_n;
						case (phase_q)
							PH_TYPE: begin
								type_q <= b;
								slot_valid <= 1'b1;
								slot.two <= 1'b0;
								slot.r0 <= mk(KIND_TYPE, b, b, ST_OK, 1'b1);
								phase_q <= PH_KLEN;
								acc_q <= '0;
								vcnt_q <= '0;
							end
							PH_KLEN, PH_VLEN: begin
								if (vbad) begin
									halted_q <= 1'b1;
									perr_q <= (phase_q == PH_KLEN) ? ST_BAD_KLEN : ST_BAD_VLEN;
								end else if (!vdone) begin
									acc_q <= acc_n;
									vcnt_q <= vcnt_n;
								end else begin
									acc_q <= '0;
									vcnt_q <= '0;
									rem_q <= acc_n[LEN_WIDTH-1:0];
									if (phase_q == PH_KLEN) begin
										phase_q <= (acc_n == 32'd0) ? PH_VLEN : PH_KEY;
									end else if (acc_n != 32'd0) begin
										phase_q <= PH_VAL;
									end else begin
										slot_valid <= 1'b1;
										slot.two <= 1'b0;
										slot.r0 <= mk(KIND_END, 8'd0, type_q,
											crc_ok ? ST_OK : ST_CRC_BAD, 1'b1);
										if (crc_ok) begin
											phase_q <= PH_CRC;
											hdr_cnt_q <= '0;
											stored_q <= '0;
										end else begin
											halted_q <= 1'b1;
											perr_q <= ST_CRC_BAD;
										end
									end
								end
							end
							PH_KEY: begin
								slot_valid <= 1'b1;
								slot.two <= 1'b0;
								slot.r0 <= mk(KIND_KEY, b, type_q, ST_OK, 1'b1);
								rem_q <= rem_dec;
								if (rem_dec == '0) begin
									phase_q <= PH_VLEN;
									acc_q <= '0;
									vcnt_q <= '0;
								end
							end
							default: begin
								slot_valid <= 1'b1;
								rem_q <= rem_dec;
								if (rem_dec == '0) begin
									slot.two <= 1'b1;
									slot.r0 <= mk(KIND_VALUE, b, type_q, ST_OK, 1'b0);
									slot.r1 <= mk(KIND_END, 8'd0, type_q,
										crc_ok ? ST_OK : ST_CRC_BAD, 1'b1);
									if (crc_ok) begin
										phase_q <= PH_CRC;
										hdr_cnt_q <= '0;
										stored_q <= '0;
									end else begin
										halted_q <= 1'b1;
										perr_q <= ST_CRC_BAD;
									end
								end else begin
									slot.two <= 1'b0;
									slot.r0 <= mk(KIND_VALUE, b, type_q, ST_OK, 1'b1);
								end
							end
						endcase
					end
				end
			end
		end
	end
endmodule

// ----- hdl/lrd_back.sv -----
// Back part: slot queue that hands out results one at a time
module lrd_back import lrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      slot_valid,
	input  slot_t     slot,
	output logic      almost_full,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);
	slot_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0] cnt_q;
	logic half_q;
	logic do_pop, slot_done;

	assign empty = (cnt_q == '0);
	assign out_item = half_q ? mem_q[rd_q].r1 : mem_q[rd_q].r0;
	assign do_pop = pop && !empty;
	assign slot_done = do_pop && (half_q || !mem_q[rd_q].two);
	// one slot may already be in flight from the front
	assign almost_full = (cnt_q >= (FIFO_AW+1)'(FIFO_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (slot_valid) mem_q[wr_q] <= slot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			half_q <= 1'b0;
		end else begin
			if (slot_valid) wr_q <= wr_q + 1'b1;
			if (do_pop) half_q <= !slot_done;
			if (slot_done) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (FIFO_AW+1)'(slot_valid) - (FIFO_AW+1)'(slot_done);
		end
	end
endmodule

// ----- hdl/log_record_deframer_crc_check_core.sv -----
// Top level of the log record deframer with CRC32C check
// Takes one log byte (or end-of-log mark) per cycle when full is low and gives its
// one or two results from a four-slot queue, one result per pop; a byte's results
// pass through the front's registered slot and then the queue before they show on
// the result side. The parser updates CRC32C and phase as each byte is taken, so
// with pop held high the block sustains one input per cycle except for the extra pop
// a record-closing value byte needs.
module log_record_deframer_crc_check_core import lrd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      push,
	output logic      full,
	input  in_item_t  in_item,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);
`include "assert_macros.svh"

	logic strict_q;
	logic slot_valid;
	slot_t slot;
	logic accept;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strict_q <= 1'b0;
		else if (cfg_we) strict_q <= cfg_wdata;
	end

	lrd_front u_front (
		.clk, .arst_n, .strict(strict_q), .in_valid(accept), .in_item,
		.slot_valid, .slot
	);

	lrd_back u_back (
		.clk, .arst_n, .slot_valid, .slot, .almost_full(full), .empty, .pop,
		.out_item
	);

	`CHK_NEXT(a_final_slot, accept && in_item.action, slot_valid && !slot.two)
	`CHK_IMPL(a_two_ends, slot_valid && slot.two,
		slot.r1.result_kind == KIND_END && !slot.r0.last)
	`CHK_IMPL(a_final_ok_lenient, !empty && out_item.result_kind == KIND_FINAL
		&& !strict_q && !$past(cfg_we), out_item.status == ST_OK)
endmodule

// ----- bench/testbench.sv -----
// Testbench for the log record deframer: directed and random logs checked against a predictor
`timescale 1ns / 1ps
module testbench import lrd_pkg::*; ();

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic push = 1'b0;
	logic full;
	in_item_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	out_item_t out_item;

	log_record_deframer_crc_check_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item)
	);

	always #6 clk = ~clk;

	// predictor state
	logic pr_strict;
	logic [2:0] pr_phase;
	logic [2:0] pr_hdr_cnt;
	logic [31:0] pr_stored;
	logic [31:0] pr_running;
	logic [31:0] pr_len_acc;
	logic [2:0] pr_vcnt;
	logic [31:0] pr_remaining;
	logic [7:0] pr_type;
	logic pr_halted;
	logic [2:0] pr_pending;

	localparam logic [2:0] PH_CRC = 3'd0, PH_TYPE = 3'd1, PH_KLEN = 3'd2,
		PH_KEY = 3'd3, PH_VLEN = 3'd4, PH_VAL = 3'd5;

	out_item_t expected_results[$];
	int mismatches = 0;
	bit quiet_mode = 0;
	bit rx_hold = 0;
	bit timed_out = 0;

	function automatic logic [31:0] crc32c_step(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 32'h82F63B78) : (c >> 1);
		return c;
	endfunction

	function automatic void clear_log_state();
		pr_phase = PH_CRC;
		pr_hdr_cnt = 0;
		pr_stored = 0;
		pr_running = '1;
		pr_len_acc = 0;
		pr_vcnt = 0;
		pr_remaining = 0;
		pr_type = 0;
		pr_halted = 0;
		pr_pending = ST_OK;
	endfunction

	function automatic void add_result(kind_t k, logic [7:0] b, status_t s);
		out_item_t r;
		r.result_kind = k;
		r.out_byte = b;
		r.record_kind = pr_type;
		r.status = s;
		r.last = 1'b1;
		if (expected_results.size() > 0 && expected_results[$].last === 1'b0)
			;
		expected_results.push_back(r);
	endfunction

	// returns -1 malformed, 0 more, 1 done
	function automatic int take_length_byte(logic [7:0] b);
		logic [31:0] shift;
		shift = 7 * pr_vcnt;
		if (shift <= 28)
			pr_len_acc = pr_len_acc | ({25'd0, b[6:0]} << shift);
		pr_vcnt = pr_vcnt + 1;
		if (b[7])
			return (pr_vcnt >= 5) ? -1 : 0;
		pr_remaining = pr_len_acc;
		pr_len_acc = 0;
		pr_vcnt = 0;
		return 1;
	endfunction

	function automatic void close_record();
		if ((pr_running ^ 32'hFFFFFFFF) == pr_stored) begin
			add_result(KIND_END, 8'd0, ST_OK);
			pr_phase = PH_CRC;
			pr_hdr_cnt = 0;
			pr_stored = 0;
		end else begin
			add_result(KIND_END, 8'd0, ST_CRC_BAD);
			pr_halted = 1;
			pr_pending = ST_CRC_BAD;
		end
	endfunction

	function automatic void predict_item(in_item_t it);
		int start_cnt;
		int v;
		status_t s;
		start_cnt = expected_results.size();
		if (it.action) begin
			s = ST_OK;
			if (pr_halted)
				s = status_t'(pr_pending);
			else if (pr_phase == PH_KLEN)
				s = ST_BAD_KLEN;
			else if (pr_phase == PH_KEY)
				s = ST_SHORT_KEY;
			else if (pr_phase == PH_VLEN)
				s = ST_BAD_VLEN;
			else if (pr_phase == PH_VAL)
				s = ST_SHORT_VAL;
			if (!pr_strict)
				s = ST_OK;
			add_result(KIND_FINAL, 8'd0, s);
			clear_log_state();
			return;
		end
		if (pr_halted)
			return;
		if (pr_phase == PH_CRC) begin
			pr_stored = pr_stored | ({24'd0, it.data_byte} << (8 * pr_hdr_cnt[1:0]));
			pr_hdr_cnt = pr_hdr_cnt + 1;
			if (pr_hdr_cnt >= 4) begin
				pr_phase = PH_TYPE;
				pr_running = '1;
			end
			return;
		end
		pr_running = crc32c_step(pr_running, it.data_byte);
		case (pr_phase)
			PH_TYPE: begin
				pr_type = it.data_byte;
				add_result(KIND_TYPE, it.data_byte, ST_OK);
				pr_phase = PH_KLEN;
				pr_len_acc = 0;
				pr_vcnt = 0;
			end
			PH_KLEN: begin
				v = take_length_byte(it.data_byte);
				if (v < 0) begin
					pr_halted = 1;
					pr_pending = ST_BAD_KLEN;
				end else if (v > 0)
					pr_phase = (pr_remaining == 0) ? PH_VLEN : PH_KEY;
			end
			PH_KEY: begin
				add_result(KIND_KEY, it.data_byte, ST_OK);
				pr_remaining = pr_remaining - 1;
				if (pr_remaining == 0) begin
					pr_phase = PH_VLEN;
					pr_len_acc = 0;
					pr_vcnt = 0;
				end
			end
			PH_VLEN: begin
				v = take_length_byte(it.data_byte);
				if (v < 0) begin
					pr_halted = 1;
					pr_pending = ST_BAD_VLEN;
				end else if (v > 0) begin
					if (pr_remaining == 0)
						close_record();
					else
						pr_phase = PH_VAL;
				end
			end
			default: begin
				add_result(KIND_VALUE, it.data_byte, ST_OK);
				pr_remaining = pr_remaining - 1;
				if (pr_remaining == 0)
					close_record();
			end
		endcase
		if (expected_results.size() - start_cnt == 2)
			expected_results[start_cnt].last = 1'b0;
	endfunction

	task automatic send_item(logic act, logic [7:0] b);
		in_item_t it;
		if (!quiet_mode && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		it.action = act;
		it.data_byte = b;
		push <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_item(it);
		@(negedge clk);
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(1'b0, b);
	endtask

	task automatic end_log();
		send_item(1'b1, 8'd0);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		push <= 1'b0;
		while (expected_results.size() > 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_strict(logic v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		pr_strict = v;
	endtask

	task automatic send_varint(logic [31:0] n);
		do begin
			send_byte({(n > 127), n[6:0]});
			n = n >> 7;
		end while (n != 0);
	endtask

	// build and send a record; corrupt flips one bit of the stored CRC
	task automatic send_record(logic [7:0] rtype, int klen, int vlen, bit corrupt);
		logic [7:0] payload[$];
		logic [31:0] c;
		logic [31:0] n;
		payload.push_back(rtype);
		n = klen;
		do begin
			payload.push_back({(n > 127), n[6:0]});
			n = n >> 7;
		end while (n != 0);
		repeat (klen) payload.push_back(8'($urandom));
		n = vlen;
		do begin
			payload.push_back({(n > 127), n[6:0]});
			n = n >> 7;
		end while (n != 0);
		repeat (vlen) payload.push_back(8'($urandom));
		c = '1;
		foreach (payload[i])
			c = crc32c_step(c, payload[i]);
		c = c ^ 32'hFFFFFFFF;
		if (corrupt)
			c = c ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			send_byte(c[8 * i +: 8]);
		foreach (payload[i])
			send_byte(payload[i]);
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: %p", out_item);
			end else begin
				e = expected_results.pop_front();
				if (out_item !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", e, out_item);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold || (!quiet_mode && $urandom_range(0, 7) == 0)) begin
			pop <= 1'b0;
			if (!rx_hold)
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
		end else
			pop <= 1'b1;
	end

	task automatic test_extremes();
		send_record(8'h00, 0, 0, 0);
		send_record(8'hFF, 1, 1, 0);
		send_record(8'hA5, 3, 2, 1);
		send_byte(8'hFF);
		end_log();
		send_record(8'h5A, 130, 1, 0);
		end_log();
		send_byte(8'h01);
		send_byte(8'h02);
		end_log();
	endtask

	task automatic test_truncation(logic mode);
		write_strict(mode);
		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < 4; i++)
				send_byte(8'h00);
			if (ph >= 1) send_byte(8'h11);
			if (ph == 2) send_byte(8'h82);
			if (ph >= 3 && ph != 2) send_byte(8'h02);
			if (ph == 3) send_byte(8'h33);
			if (ph == 4) send_byte(8'h33);
			if (ph >= 4) send_byte(8'h33);
			if (ph == 5) begin
				send_byte(8'h03);
				send_byte(8'h44);
			end
			end_log();
		end
	endtask

	task automatic test_bad_varints(logic mode);
		write_strict(mode);
		send_record(8'h10, 2, 1, 0);
		for (int i = 0; i < 4; i++) send_byte(8'h00);
		send_byte(8'h20);
		repeat (5) send_byte(8'hFF);
		send_byte(8'h07);
		end_log();
		for (int i = 0; i < 4; i++) send_byte(8'h00);
		send_byte(8'h21);
		send_byte(8'h00);
		repeat (5) send_byte(8'h80);
		end_log();
		for (int i = 0; i < 4; i++) send_byte(8'h00);
		send_byte(8'h22);
		send_byte(8'h00);
		repeat (4) send_byte(8'hFF);
		send_byte(8'h7F);
		end_log();
		send_record(8'h30, 0, 1, 1);
		send_record(8'h31, 0, 0, 0);
		end_log();
	endtask

	task automatic test_backpressure();
		rx_hold = 1;
		fork
			begin
				repeat (200) @(negedge clk);
				rx_hold = 0;
			end
			begin
				for (int i = 0; i < 12; i++)
					send_record(8'($urandom), 1, 1, 0);
				for (int i = 0; i < 6; i++)
					send_record(8'($urandom), 2, 1, 0);
			end
		join
		end_log();
		wait_drained();
	endtask

	task automatic test_random(int count, logic mode);
		int sent;
		int r;
		write_strict(mode);
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 19);
			if (r < 14) begin
				send_record(8'($urandom), $urandom_range(0, 6), $urandom_range(0, 6),
					$urandom_range(0, 9) == 0);
				sent += 12;
			end else if (r < 16) begin
				send_byte(8'($urandom));
				sent++;
			end else begin
				end_log();
				sent++;
			end
		end
		end_log();
	endtask

	initial begin
		pr_strict = 0;
		clear_log_state();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_extremes();
		test_truncation(1'b1);
		test_bad_varints(1'b1);
		test_truncation(1'b0);
		test_bad_varints(1'b0);
		test_backpressure();
		test_random(550, 1'b1);
		test_random(450, 1'b0);
		write_strict(1'b1);
		quiet_mode = 1;
		test_random(300, 1'b1);
		wait_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0 && !timed_out)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#3000000;
		timed_out = 1;
		$display("testbench: errors");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/lrd_pkg.sv
hdl/lrd_front.sv
hdl/lrd_back.sv
hdl/log_record_deframer_crc_check_core.sv
bench/testbench.sv
